// File: design/cva_pkg.sv
// ----------------------------------------------------------------------------
// cva_pkg
// Shared widths, defaults and the arctangent step table for the CORDIC
// vectoring angle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cva_pkg;

    // Datapath width for x and y; holds 16-bit inputs scaled by 1024 with growth
    localparam int DATA_W = 32;
    // Width of the angle word
    localparam int ANGLE_W = 16;
    // Width of the input fields on the ports
    localparam int FIELD_W = 16;
    // Input prescale of 1024 expressed as a left shift
    localparam int SCALE_SHIFT = 10;

    // Default configuration
    localparam int DEF_ITERATIONS      = 15;
    localparam int DEF_ANGLE_FRAC_BITS = 14;
    localparam int DEF_INPUT_WIDTH     = 16;

    // Table geometry
    localparam int TABLE_LEN  = 15;
    localparam int TABLE_FRAC = 14;

    typedef logic [ANGLE_W-1:0] t_angle;

    // floor(atan(2^-i) * 2^14), i = 0..14
    localparam t_angle ATAN_TABLE [TABLE_LEN] = '{
        16'd12867, 16'd7596, 16'd4013, 16'd2037, 16'd1022, 16'd511, 16'd255,
        16'd127, 16'd63, 16'd31, 16'd15, 16'd7, 16'd3, 16'd1, 16'd0
    };

    // Step angle at a given fraction width
    function automatic t_angle atan_entry(input int idx, input int frac);
        t_angle ent;
        ent = '0;
        if (idx >= 0 && idx < TABLE_LEN) begin
            ent = ATAN_TABLE[idx] >> (TABLE_FRAC - frac);
        end
        return ent;
    endfunction

endpackage

`default_nettype wire

// File: design/cordic_vectoring_atan_unit.sv
// ----------------------------------------------------------------------------
// cordic_vectoring_atan_unit
// Angle of an (x, y) vector by CORDIC vectoring, one micro-rotation per
// pipeline stage. Valid for x > 0; no quadrant correction.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------
//  input     | in        | start, busy (always 0) | i_x_in, i_y_in
//  result    | out       | o_valid strobe         | o_angle_out
//
//  The pipeline holds one prescale register, then one register per
//  micro-rotation stage. A new word is taken every cycle.
//  Reset clears only the valid bits of the pipeline; payload is not reset.
//  Busy stays low: the receiver cannot stall and the pipeline never fills.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_vectoring_atan_unit #(
    parameter int ITERATIONS      = cva_pkg::DEF_ITERATIONS,
    parameter int ANGLE_FRAC_BITS = cva_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int INPUT_WIDTH     = cva_pkg::DEF_INPUT_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [cva_pkg::FIELD_W-1:0]  i_x_in,
    input  wire logic signed [cva_pkg::FIELD_W-1:0]  i_y_in,
    output logic                                     o_valid,
    output logic signed [cva_pkg::ANGLE_W-1:0]       o_angle_out
);
    import cva_pkg::*;

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;

    logic signed [INPUT_WIDTH-1:0] x_low;
    logic signed [INPUT_WIDTH-1:0] y_low;
    logic signed [DATA_W-1:0]      n_x;
    logic signed [DATA_W-1:0]      n_y;

    logic                     valid_pipe [ITERATIONS+1];
    logic signed [DATA_W-1:0] x_pipe     [ITERATIONS+1];
    logic signed [DATA_W-1:0] y_pipe     [ITERATIONS+1];
    t_angle                   acc_pipe   [ITERATIONS+1];

    // Sign-extend the used input bits and scale by 1024
    always_comb begin
        x_low = i_x_in[INPUT_WIDTH-1:0];
        y_low = i_y_in[INPUT_WIDTH-1:0];
        n_x   = DATA_W'(x_low) <<< SCALE_SHIFT;
        n_y   = DATA_W'(y_low) <<< SCALE_SHIFT;
    end

    // Accept a word whenever start is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign valid_pipe[0] = r_valid;
    assign x_pipe[0]     = r_x;
    assign y_pipe[0]     = r_y;
    assign acc_pipe[0]   = '0;

    // Chain of micro-rotation stages
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
        cva_stage #(
            .STAGE           (g),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_pipe[g]),
            .i_x     (x_pipe[g]),
            .i_y     (y_pipe[g]),
            .i_acc   (acc_pipe[g]),
            .o_valid (valid_pipe[g+1]),
            .o_x     (x_pipe[g+1]),
            .o_y     (y_pipe[g+1]),
            .o_acc   (acc_pipe[g+1])
        );
    end

    assign busy        = 1'b0;
    assign o_valid     = valid_pipe[ITERATIONS];
    assign o_angle_out = acc_pipe[ITERATIONS];

endmodule

`default_nettype wire

// File: design/cva_stage.sv
// ----------------------------------------------------------------------------
// cva_stage
// One registered CORDIC vectoring micro-rotation: steer on the sign of y,
// add or subtract the shifted partner and the step angle.
// ----------------------------------------------------------------------------
`default_nettype none

module cva_stage #(
    parameter int STAGE           = 0,
    parameter int ANGLE_FRAC_BITS = cva_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [cva_pkg::DATA_W-1:0] i_x,
    input  wire logic signed [cva_pkg::DATA_W-1:0] i_y,
    input  wire cva_pkg::t_angle                   i_acc,
    output logic                                   o_valid,
    output logic signed [cva_pkg::DATA_W-1:0]      o_x,
    output logic signed [cva_pkg::DATA_W-1:0]      o_y,
    output cva_pkg::t_angle                        o_acc
);
    import cva_pkg::*;

    localparam t_angle STEP_ANGLE = atan_entry(STAGE, ANGLE_FRAC_BITS);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    t_angle                   r_acc;

    logic signed [DATA_W-1:0] n_x;
    logic signed [DATA_W-1:0] n_y;
    t_angle                   n_acc;
    logic signed [DATA_W-1:0] x_sh;
    logic signed [DATA_W-1:0] y_sh;
    logic                     y_pos;

    // Rotate toward y = 0; zero y takes the negative branch
    always_comb begin
        x_sh  = i_x >>> STAGE;
        y_sh  = i_y >>> STAGE;
        y_pos = !i_y[DATA_W-1] && (i_y != '0);
        if (y_pos) begin
            n_x   = i_x + y_sh;
            n_y   = i_y - x_sh;
            n_acc = i_acc + STEP_ANGLE;
        end else begin
            n_x   = i_x - y_sh;
            n_y   = i_y + x_sh;
            n_acc = i_acc - STEP_ANGLE;
        end
    end

    // Advance valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold the word payload
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;

endmodule

`default_nettype wire

// File: tb/sv/cordic_vectoring_atan_unit_test.sv
// ----------------------------------------------------------------------------
// cordic_vectoring_atan_unit_test
// Drives (x, y) vectors into the CORDIC vectoring angle unit and checks each
// angle word against a bit-exact predictor of the 15 micro-rotations. Runs a
// directed set of corner vectors and then random vectors under changing
// amounts of input idling.
// ----------------------------------------------------------------------------
module cordic_vectoring_atan_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS      = 15;
    localparam int FRAC_BITS  = 14;
    localparam int IN_WIDTH   = 16;
    localparam int PIPE_DEPTH = STEPS + 1;
    localparam int QUIET_MAX  = 4000;

    // floor(atan(2^-i) * 2^14)
    localparam int ATAN_STEP [0:14] = '{
        12867, 7596, 4013, 2037, 1022, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0
    };

    typedef struct packed {
        logic [cva_pkg::FIELD_W-1:0] x;
        logic [cva_pkg::FIELD_W-1:0] y;
    } t_vec_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic signed [cva_pkg::FIELD_W-1:0] i_x_in = '0;
    logic signed [cva_pkg::FIELD_W-1:0] i_y_in = '0;
    logic o_valid;
    logic signed [cva_pkg::ANGLE_W-1:0] o_angle_out;

    t_vec_word       vec_pending [$];
    cva_pkg::t_angle angle_due [$];
    int              vec_total  = 0;
    int              vec_taken  = 0;
    int              idle_pct   = 0;
    int              fail_cnt   = 0;
    int              quiet_cyc  = 0;
    logic            took_word  = 1'b0;

    cordic_vectoring_atan_unit #(
        .ITERATIONS      (STEPS),
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .INPUT_WIDTH     (IN_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .o_valid     (o_valid),
        .o_angle_out (o_angle_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Accumulate the vectoring angle of one word, steering on y > 0
    function automatic cva_pkg::t_angle vector_angle(input logic [cva_pkg::FIELD_W-1:0] xv,
                                                     input logic [cva_pkg::FIELD_W-1:0] yv);
        longint xr, yr, xs, ys, acc;
        xr  = longint'($signed(xv[IN_WIDTH-1:0])) * 1024;
        yr  = longint'($signed(yv[IN_WIDTH-1:0])) * 1024;
        acc = 0;
        for (int i = 0; i < STEPS && i < 15; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr > 0) begin
                xr  = xr + ys;
                yr  = yr - xs;
                acc = acc + (ATAN_STEP[i] >> (14 - FRAC_BITS));
            end else begin
                xr  = xr - ys;
                yr  = yr + xs;
                acc = acc - (ATAN_STEP[i] >> (14 - FRAC_BITS));
            end
        end
        return acc[cva_pkg::ANGLE_W-1:0];
    endfunction

    task automatic queue_vector(input int xv, input int yv);
        t_vec_word w;
        w.x = xv[cva_pkg::FIELD_W-1:0];
        w.y = yv[cva_pkg::FIELD_W-1:0];
        vec_pending.push_back(w);
        vec_total++;
    endtask

    // Mostly right-half-plane vectors, plus full-range, tiny and edge words
    task automatic queue_random_vectors(input int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                queue_vector($urandom_range(32767, 1), $urandom_range(65535));
            end else if (kind < 75) begin
                queue_vector($urandom_range(65535), $urandom_range(65535));
            end else if (kind < 88) begin
                queue_vector(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64);
            end else if (kind < 94) begin
                queue_vector($urandom_range(65535), 0);
            end else begin
                queue_vector($urandom_range(1) ? 32767 : -32768,
                             $urandom_range(1) ? 32767 : -32768);
            end
        end
    endtask

    task automatic drain_pending();
        while (vec_pending.size() != 0) @(posedge i_clk);
    endtask

    // Present the next word at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        t_vec_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_word) begin
            if (vec_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                w = vec_pending.pop_front();
                start  <= 1'b1;
                i_x_in <= w.x;
                i_y_in <= w.y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Check each result against the oldest angle due, then log the new word
    always @(posedge i_clk) begin
        cva_pkg::t_angle want;
        if (i_rst_n && o_valid) begin
            if (angle_due.size() == 0) begin
                $display("%0t: angle word with none due: expected none, actual %0d",
                         $time, o_angle_out);
                fail_cnt++;
            end else begin
                want = angle_due.pop_front();
                if (o_angle_out !== want) begin
                    $display("%0t: angle_out mismatch: expected %0d, actual %0d",
                             $time, $signed(want), o_angle_out);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            angle_due.push_back(vector_angle(i_x_in, i_y_in));
            vec_taken++;
        end
        took_word <= i_rst_n && start && !busy;
    end

    // Stop a run that has gone silent for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
        if (quiet_cyc >= QUIET_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // Hold reset, then release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: extremes, zero y, x not positive, sign boundaries
        idle_pct = 0;
        queue_vector(32767, 0);
        queue_vector(32767, 32767);
        queue_vector(32767, -32768);
        queue_vector(-32768, -32768);
        queue_vector(-32768, 32767);
        queue_vector(-32768, 0);
        queue_vector(0, 0);
        queue_vector(1, 0);
        queue_vector(100, 0);
        queue_vector(0, 1);
        queue_vector(0, -1);
        queue_vector(0, 32767);
        queue_vector(0, -32768);
        queue_vector(1, 1);
        queue_vector(1, -1);
        queue_vector(-1, -1);
        queue_vector(-1, 0);
        queue_vector(-100, 50);
        queue_vector(32767, 1);
        queue_vector(32767, -1);
        queue_vector(2, 32767);
        queue_vector(12345, -6789);
        queue_vector(-5555, -7777);
        drain_pending();

        // Random vectors, back to back
        queue_random_vectors(290);
        drain_pending();

        // Sparse input: mostly idle
        idle_pct = 74;
        queue_random_vectors(290);
        drain_pending();

        // Back to back again
        idle_pct = 0;
        queue_random_vectors(280);
        drain_pending();

        // Light idling
        idle_pct = 20;
        queue_random_vectors(290);

        // Wait for every word to be taken and every angle to come back
        while (vec_taken != vec_total || angle_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
